// File: src/escape_sequence_decoder_assert.svh
// assertion macros for the escape sequence decoder
`ifndef ESCAPE_SEQUENCE_DECODER_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ESD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("esd check failed");

// next-cycle implication, checked out of reset
`define ESD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("esd check failed");

`endif

// File: src/esd_pkg.sv
// shared types and constants for the escape sequence decoder
`timescale 1ns / 1ps
package esd_pkg;

	localparam int COUNT_BITS = 16;
	localparam int SHOW_BITS  = 16;
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = $clog2(Q_DEPTH);
	localparam int Q_CW       = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_CHAR   = 2'd0,
		KIND_END    = 2'd1,
		KIND_BAD    = 2'd2,
		KIND_UNTERM = 2'd3
	} kind_t;

	typedef struct packed {
		logic       v;
		kind_t      kind;
		logic [7:0] val;
	} res_t;

	// at most one word per input byte: up to two results, then optional count clear
	typedef struct packed {
		res_t r0;
		res_t r1;
		logic clr;
	} cmd_t;

	typedef logic [COUNT_BITS-1:0] count_t;

	function automatic logic [SHOW_BITS-1:0] show_count(input count_t c);
		logic [31:0] wide;
		wide = 32'(c);
		if (wide > 32'((64'd1 << SHOW_BITS) - 64'd1))
			return '1;
		return wide[SHOW_BITS-1:0];
	endfunction

endpackage

// File: src/escape_sequence_decoder.sv
// top level of the escape sequence decoder
//
//  channel | signals                                        | role
//  in      | in_valid, in_ready, in_byte                    | one raw string byte per word
//  out     | out_valid, out_ready, kind, char_value,        | one decoded result per word
//          | char_count, last_of_run                        |
//
// the parser takes one byte per cycle while the four-word queue has room
// each byte yields zero, one or two results; the sequencer sends one per cycle
// while the output slot is free, so a byte with two results stays at the queue head
// results pass through the queue and then the output register
// a byte with no result but a counter clear is popped by the sequencer, no output
// reset is asynchronous; no clearing pass, the block takes bytes right after it
`timescale 1ns / 1ps
`include "escape_sequence_decoder_assert.svh"
module escape_sequence_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  char_value,
	output logic [15:0] char_count,
	output logic        last_of_run
);
	import esd_pkg::*;

	cmd_t push_word, head;
	logic push, q_full, pop, head_valid;

	esd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.push     (push),
		.cmd      (push_word)
	);

	esd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_word  (push_word),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	esd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.char_value  (char_value),
		.char_count  (char_count),
		.last_of_run (last_of_run)
	);

	// only decoded characters carry a value
	`ESD_ASSERT_NOW(a_val_only_char, out_valid && kind != KIND_CHAR, char_value == 8'd0)
	// a decoded character has always been counted
	`ESD_ASSERT_NOW(a_char_counted, out_valid && kind == KIND_CHAR, char_count != 16'd0)
	// string end and unterminated escape close their byte's results
	`ESD_ASSERT_NOW(a_end_is_last, out_valid && (kind == KIND_END || kind == KIND_UNTERM),
		last_of_run)
	// a stalled head word with two results is never dropped before its second result
	`ESD_ASSERT_NEXT(a_pair_held, head_valid && head.r1.v && !pop, head_valid)

endmodule

// File: src/esd_front.sv
// front end: parse state machine, turns each byte into at most one result word
`timescale 1ns / 1ps
module esd_front (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        q_full,
	output logic        push,
	output esd_pkg::cmd_t cmd
);
	import esd_pkg::*;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_X_LO   = 8'h78;
	localparam logic [7:0] CH_X_UP   = 8'h58;

	typedef enum logic [4:0] {
		MODE_IDLE = 5'b00001,
		MODE_ESC  = 5'b00010,
		MODE_HEX  = 5'b00100,
		MODE_OCT  = 5'b01000,
		MODE_ERR  = 5'b10000
	} mode_t;

	// simple escape letters; bit 8 marks a known letter
	function automatic logic [8:0] esc_lookup(input logic [7:0] b);
		unique case (b)
			8'h61:   return {1'b1, 8'd7};
			8'h62:   return {1'b1, 8'd8};
			8'h74:   return {1'b1, 8'd9};
			8'h6E:   return {1'b1, 8'd10};
			8'h76:   return {1'b1, 8'd11};
			8'h66:   return {1'b1, 8'd12};
			8'h72:   return {1'b1, 8'd13};
			8'h3F, 8'h27, 8'h22, CH_BSLASH: return {1'b1, b};
			default: return 9'd0;
		endcase
	endfunction

	function automatic logic [4:0] hex_lookup(input logic [7:0] b);
		logic [7:0] t;
		t = 8'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			t = b - 8'h30;
			return {1'b1, t[3:0]};
		end
		if (b >= 8'h41 && b <= 8'h46) begin
			t = b - 8'h37;
			return {1'b1, t[3:0]};
		end
		if (b >= 8'h61 && b <= 8'h66) begin
			t = b - 8'h57;
			return {1'b1, t[3:0]};
		end
		return 5'd0;
	endfunction

	mode_t      mode_q, mode_d;
	logic [7:0] acc_q, acc_d;
	logic [1:0] dcnt_q, dcnt_d;
	logic       plain;
	logic [4:0] hx;
	logic [8:0] ev;
	logic       is_oct;
	res_t       pr;

	assign in_ready = !q_full;
	assign hx       = hex_lookup(in_byte);
	assign ev       = esc_lookup(in_byte);
	assign is_oct   = (in_byte >= 8'h30) && (in_byte <= 8'h37);

	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		dcnt_d = dcnt_q;
		cmd    = '0;
		plain  = 1'b0;
		pr     = '0;
		unique case (mode_q)
			MODE_HEX, MODE_OCT: begin
				if ((mode_q == MODE_HEX) ? hx[4] : is_oct) begin
					if (dcnt_q == ((mode_q == MODE_HEX) ? 2'd2 : 2'd3)) begin
						cmd.r0 = '{v: 1'b1, kind: KIND_BAD, val: 8'd0};
						mode_d = MODE_ERR;
					end else begin
						acc_d  = (mode_q == MODE_HEX) ? {acc_q[3:0], hx[3:0]}
						                              : {acc_q[4:0], in_byte[2:0]};
						dcnt_d = dcnt_q + 2'd1;
					end
				end else if (dcnt_q == 2'd0) begin
					// escape with no digits
					if (in_byte == CH_NUL) begin
						cmd.r0  = '{v: 1'b1, kind: KIND_UNTERM, val: 8'd0};
						cmd.clr = 1'b1;
						mode_d  = MODE_IDLE;
					end else begin
						cmd.r0 = '{v: 1'b1, kind: KIND_BAD, val: 8'd0};
						mode_d = MODE_ERR;
					end
				end else begin
					cmd.r0 = '{v: 1'b1, kind: KIND_CHAR, val: acc_q};
					plain  = 1'b1;
				end
			end
			MODE_ESC: begin
				acc_d  = 8'd0;
				dcnt_d = 2'd0;
				if (in_byte == CH_NUL) begin
					cmd.r0  = '{v: 1'b1, kind: KIND_UNTERM, val: 8'd0};
					cmd.clr = 1'b1;
					mode_d  = MODE_IDLE;
				end else if (in_byte == CH_X_LO || in_byte == CH_X_UP) begin
					mode_d = MODE_HEX;
				end else if (in_byte == CH_ZERO) begin
					mode_d = MODE_OCT;
				end else if (ev[8]) begin
					cmd.r0 = '{v: 1'b1, kind: KIND_CHAR, val: ev[7:0]};
					mode_d = MODE_IDLE;
				end else begin
					cmd.r0 = '{v: 1'b1, kind: KIND_BAD, val: 8'd0};
					mode_d = MODE_ERR;
				end
			end
			MODE_ERR: begin
				// silent until the terminator
				if (in_byte == CH_NUL) begin
					cmd.clr = 1'b1;
					mode_d  = MODE_IDLE;
					acc_d   = 8'd0;
					dcnt_d  = 2'd0;
				end
			end
			MODE_IDLE: plain = 1'b1;
			default:   plain = 1'b1;
		endcase

		if (plain) begin
			mode_d = MODE_IDLE;
			acc_d  = 8'd0;
			dcnt_d = 2'd0;
			if (in_byte == CH_NUL) begin
				pr      = '{v: 1'b1, kind: KIND_END, val: 8'd0};
				cmd.clr = 1'b1;
			end else if (in_byte == CH_BSLASH) begin
				mode_d = MODE_ESC;
			end else begin
				pr = '{v: 1'b1, kind: KIND_CHAR, val: in_byte};
			end
			// terminator after pending digits lands in the second slot
			if (cmd.r0.v)
				cmd.r1 = pr;
			else
				cmd.r0 = pr;
		end
	end

	assign push = in_valid && in_ready && (cmd.r0.v || cmd.clr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= 8'd0;
			dcnt_q <= 2'd0;
		end else if (in_valid && in_ready) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			dcnt_q <= dcnt_d;
		end
	end

endmodule

// File: src/esd_queue.sv
// short word queue between the parser and the result sequencer
`timescale 1ns / 1ps
module esd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  esd_pkg::cmd_t push_word,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output esd_pkg::cmd_t head
);
	import esd_pkg::*;

	cmd_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_CW-1:0] cnt_q;

	assign full       = (cnt_q == Q_CW'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: src/esd_back.sv
// back end: plays out each word's results, keeps the decoded-char counter
`timescale 1ns / 1ps
module esd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  esd_pkg::cmd_t head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    kind,
	output logic [7:0]    char_value,
	output logic [15:0]   char_count,
	output logic          last_of_run
);
	import esd_pkg::*;

	logic   sel_q;
	count_t cnt_q, cnt_d, cnt_inc;
	res_t   cur;
	logic   is_last, emit, slot_free;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  val_q;
	logic [15:0] count_q;
	logic        last_q;

	assign slot_free = !out_valid_q || out_ready;
	assign cur       = sel_q ? head.r1 : head.r0;
	assign is_last   = sel_q || !head.r1.v;
	assign emit      = head_valid && head.r0.v && slot_free;
	// a word with no results only clears the counter
	assign pop       = head_valid && (!head.r0.v || (emit && is_last));
	assign cnt_inc   = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

	always_comb begin
		cnt_d = cnt_q;
		if (head_valid && !head.r0.v)
			cnt_d = '0;
		else if (emit && is_last && head.clr)
			cnt_d = '0;
		else if (emit && cur.kind == KIND_CHAR)
			cnt_d = cnt_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (emit) begin
				sel_q       <= !is_last;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= cur.kind;
			val_q   <= (cur.kind == KIND_CHAR) ? cur.val : 8'd0;
			count_q <= (cur.kind == KIND_CHAR) ? show_count(cnt_inc) : show_count(cnt_q);
			last_q  <= is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign char_value  = val_q;
	assign char_count  = count_q;
	assign last_of_run = last_q;

endmodule

// File: tb/escape_sequence_decoder_tb.sv
// self-checking testbench for the escape sequence decoder
`timescale 1ns / 1ps
module escape_sequence_decoder_tb;
	import esd_pkg::*;

	localparam logic [7:0] BSLASH      = 8'h5C;
	localparam int         STALL_LIMIT = 2000;
	localparam int         PHASE_BYTES = 200;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ESC,
		ST_HEX,
		ST_OCT,
		ST_ERR
	} esc_state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  chr;
		logic [15:0] cnt;
		logic        last;
	} esd_word_t;

	typedef struct {
		logic [7:0] b;
		bit         typed;
		esd_word_t  word;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  char_value;
	logic [15:0] char_count;
	logic        last_of_run;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;
	int quiet_cycles = 0;
	int live_bytes = 0;

	// decoder model state
	esc_state_t  esc_state;
	logic [7:0]  digit_val;
	logic [1:0]  digit_num;
	logic [15:0] chars_seen;
	esd_word_t   step_words [2];
	int          step_n;

	esd_word_t expected_words [$];

	// directed stimulus; typed rows carry their single result
	dir_row_t dir_tab [28] = '{
		'{8'h00, 1'b1, '{KIND_END, 8'h00, 16'd0, 1'b1}},
		'{8'hFF, 1'b1, '{KIND_CHAR, 8'hFF, 16'd1, 1'b1}},
		'{BSLASH, 1'b0, '0},
		'{"x", 1'b0, '0},
		'{"A", 1'b0, '0},
		'{"b", 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{BSLASH, 1'b0, '0},
		'{8'h00, 1'b1, '{KIND_UNTERM, 8'h00, 16'd0, 1'b1}},
		'{BSLASH, 1'b0, '0},
		'{"0", 1'b0, '0},
		'{"0", 1'b0, '0},
		'{BSLASH, 1'b0, '0},
		'{"q", 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{BSLASH, 1'b0, '0},
		'{"X", 1'b0, '0},
		'{"1", 1'b0, '0},
		'{"2", 1'b0, '0},
		'{"3", 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{BSLASH, 1'b0, '0},
		'{"0", 1'b0, '0},
		'{8'h00, 1'b1, '{KIND_UNTERM, 8'h00, 16'd0, 1'b1}},
		'{BSLASH, 1'b0, '0},
		'{"x", 1'b0, '0},
		'{"g", 1'b0, '0},
		'{8'h00, 1'b0, '0}
	};

	escape_sequence_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.char_value  (char_value),
		.char_count  (char_count),
		.last_of_run (last_of_run)
	);

	always #5 clk = ~clk;

	function automatic int hex_digit(input logic [7:0] b);
		if (b >= "0" && b <= "9")
			return int'(b - "0");
		if (b >= "A" && b <= "F")
			return int'(b - "A") + 10;
		if (b >= "a" && b <= "f")
			return int'(b - "a") + 10;
		return -1;
	endfunction

	function automatic int escape_code(input logic [7:0] b);
		case (b)
			"a": return 7;
			"b": return 8;
			"t": return 9;
			"n": return 10;
			"v": return 11;
			"f": return 12;
			"r": return 13;
			"?", "'", "\"", BSLASH: return int'(b);
			default: return -1;
		endcase
	endfunction

	function automatic void clear_string();
		esc_state  = ST_IDLE;
		digit_val  = 8'h00;
		digit_num  = 2'd0;
		chars_seen = 16'd0;
	endfunction

	function automatic void put_word(input kind_t k, input logic [7:0] v);
		step_words[step_n] = '{k, (k == KIND_CHAR) ? v : 8'h00, chars_seen, 1'b0};
		step_n++;
	endfunction

	function automatic void put_char(input logic [7:0] v);
		if (chars_seen != 16'hFFFF)
			chars_seen++;
		put_word(KIND_CHAR, v);
	endfunction

	// x, X or 0 with no digit after it
	function automatic void no_digits(input logic [7:0] b);
		if (b == 8'h00) begin
			put_word(KIND_UNTERM, 8'h00);
			clear_string();
		end else begin
			put_word(KIND_BAD, 8'h00);
			esc_state = ST_ERR;
		end
	endfunction

	// advances the decoder state by one raw byte, leaves its results in step_words
	function automatic void decode_byte(input logic [7:0] b);
		bit plain;
		int d;
		step_n = 0;
		plain = 1'b0;
		case (esc_state)
			ST_HEX: begin
				d = hex_digit(b);
				if (d >= 0) begin
					if (digit_num >= 2'd2) begin
						put_word(KIND_BAD, 8'h00);
						esc_state = ST_ERR;
					end else begin
						digit_val = {digit_val[3:0], 4'(d)};
						digit_num++;
					end
				end else if (digit_num == 2'd0) begin
					no_digits(b);
				end else begin
					put_char(digit_val);
					plain = 1'b1;
				end
			end
			ST_OCT: begin
				if (b >= "0" && b <= "7") begin
					if (digit_num >= 2'd3) begin
						put_word(KIND_BAD, 8'h00);
						esc_state = ST_ERR;
					end else begin
						digit_val = {digit_val[4:0], b[2:0]};
						digit_num++;
					end
				end else if (digit_num == 2'd0) begin
					no_digits(b);
				end else begin
					put_char(digit_val);
					plain = 1'b1;
				end
			end
			ST_ESC: begin
				digit_val = 8'h00;
				digit_num = 2'd0;
				if (b == 8'h00) begin
					put_word(KIND_UNTERM, 8'h00);
					clear_string();
				end else if (b == "x" || b == "X") begin
					esc_state = ST_HEX;
				end else if (b == "0") begin
					esc_state = ST_OCT;
				end else begin
					d = escape_code(b);
					if (d >= 0) begin
						put_char(8'(d));
						esc_state = ST_IDLE;
					end else begin
						put_word(KIND_BAD, 8'h00);
						esc_state = ST_ERR;
					end
				end
			end
			ST_ERR: begin
				if (b == 8'h00)
					clear_string();
			end
			default: plain = 1'b1;
		endcase

		// byte that ended a digit run is handled as an ordinary byte too
		if (plain) begin
			esc_state = ST_IDLE;
			digit_val = 8'h00;
			digit_num = 2'd0;
			if (b == 8'h00) begin
				put_word(KIND_END, 8'h00);
				clear_string();
			end else if (b == BSLASH) begin
				esc_state = ST_ESC;
			end else begin
				put_char(b);
			end
		end
		if (step_n > 0)
			step_words[step_n - 1].last = 1'b1;
	endfunction

	function automatic void queue_predicted();
		for (int i = 0; i < step_n; i++)
			expected_words.push_back(step_words[i]);
	endfunction

	// drives one word and waits for it to be taken, then updates the model
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			in_byte  = 8'($urandom);
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_byte  = b;
		do
			@(posedge clk);
		while (!in_ready);
		if (esc_state != ST_ERR)
			live_bytes++;
		decode_byte(b);
	endtask

	task automatic run_string();
		logic [7:0] s [$];
		logic [7:0] c;
		int nseg;
		int r;
		int k;
		string hexset;
		string esc_letters;
		hexset      = "0123456789abcdefABCDEF";
		esc_letters = "abtnvfr?'\"\\";
		nseg = $urandom_range(0, 8);
		for (int i = 0; i < nseg; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				c = 8'($urandom_range(1, 255));
				s.push_back(c);
				if (c == BSLASH)
					s.push_back(BSLASH);
			end else if (r < 58) begin
				s.push_back(BSLASH);
				s.push_back(esc_letters[$urandom_range(0, 10)]);
			end else if (r < 72) begin
				s.push_back(BSLASH);
				if ($urandom_range(0, 1))
					s.push_back("x");
				else
					s.push_back("X");
				k = $urandom_range(1, 2);
				repeat (k) s.push_back(hexset[$urandom_range(0, 21)]);
			end else if (r < 86) begin
				s.push_back(BSLASH);
				s.push_back("0");
				k = $urandom_range(1, 3);
				repeat (k) s.push_back(8'("0" + $urandom_range(0, 7)));
			end else begin
				case ($urandom_range(0, 4))
					0: begin
						do
							c = 8'($urandom_range(1, 255));
						while (escape_code(c) >= 0 || c == "x" || c == "X" || c == "0");
						s.push_back(BSLASH);
						s.push_back(c);
					end
					1: begin
						s.push_back(BSLASH);
						s.push_back("x");
						repeat (3) s.push_back(hexset[$urandom_range(0, 21)]);
					end
					2: begin
						s.push_back(BSLASH);
						s.push_back("0");
						repeat (4) s.push_back(8'("0" + $urandom_range(0, 7)));
					end
					3: begin
						do
							c = 8'($urandom_range(1, 255));
						while (hex_digit(c) >= 0);
						s.push_back(BSLASH);
						k = $urandom_range(0, 2);
						if (k == 0)
							s.push_back("x");
						else if (k == 1)
							s.push_back("X");
						else
							s.push_back("0");
						s.push_back(c);
					end
					default: s.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end
		// string cut off inside an escape
		if ($urandom_range(0, 9) == 0) begin
			s.push_back(BSLASH);
			if ($urandom_range(0, 1))
				s.push_back("x");
		end
		s.push_back(8'h00);
		foreach (s[i]) begin
			send_byte(s[i]);
			queue_predicted();
		end
	endtask

	task automatic check_field(input string what, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			fail_count++;
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what,
				exp_v, act_v);
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n)
			out_ready = 1'b0;
		else
			out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		esd_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				fail_count++;
				$display("%0t ns: unexpected word, expected none, got kind %0d value %0h count %0d",
					$time, kind, char_value, char_count);
			end else begin
				w = expected_words.pop_front();
				check_field("kind", 16'(w.kind), 16'(kind));
				check_field("char_value", 16'(w.chr), 16'(char_value));
				check_field("char_count", w.cnt, char_count);
				check_field("last_of_run", 16'(w.last), 16'(last_of_run));
			end
		end
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		clear_string();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 45 : 0;
			recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 36 : 0;
			if (phase == 0) begin
				foreach (dir_tab[i]) begin
					send_byte(dir_tab[i].b);
					if (dir_tab[i].typed)
						expected_words.push_back(dir_tab[i].word);
					else
						queue_predicted();
				end
			end
			live_bytes = 0;
			while (live_bytes < PHASE_BYTES)
				run_string();
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: escape_sequence_decoder.f
+incdir+src
src/esd_pkg.sv
src/esd_front.sv
src/esd_queue.sv
src/esd_back.sv
src/escape_sequence_decoder.sv
tb/escape_sequence_decoder_tb.sv
